[hdl/mrfb_pkg.sv]
package mrfb_pkg;

   localparam logic [2:0] CMD_ACQUIRE  = 3'd0;
   localparam logic [2:0] CMD_RELEASE  = 3'd1;
   localparam logic [2:0] CMD_PUSH     = 3'd2;
   localparam logic [2:0] CMD_POP      = 3'd3;
   localparam logic [2:0] CMD_MARK_END = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NO_RING = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_STALE   = 3'd4;

   localparam int CMD_W    = 3;
   localparam int RING_W   = 5;
   localparam int TAG_W    = 16;
   localparam int SAMPLE_W = 32;
   localparam int LEVEL_W  = 14;
   localparam int STATUS_W = 3;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [RING_W-1:0]   ring_id;
      logic [TAG_W-1:0]    gen_tag;
      logic [SAMPLE_W-1:0] left_sample;
      logic [SAMPLE_W-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RING_W-1:0]   ring_out;
      logic [TAG_W-1:0]    gen_out;
      logic [SAMPLE_W-1:0] left_out;
      logic [SAMPLE_W-1:0] right_out;
      logic [LEVEL_W-1:0]  level;
      logic                end_flag;
   } rsp_type;

endpackage

[hdl/mrfb_if.sv]
interface mrfb_req_if import mrfb_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mrfb_rsp_if import mrfb_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/multi_ring_frame_buffer_unit.sv]
// Pool of stereo frame rings sharing one synchronous frame memory. Each
// transaction first latches the request and, for a pop, reads the frame
// memory into a registered read port; it then reads and updates the ring's
// descriptor (held in registers) and loads the response register, which
// offers the response. A new request is accepted once the update step is
// over and the response register is empty or being taken, so no new
// transaction is accepted while the last one is still being updated.
// Acquire grants the lowest free ring. Ring storage is not cleared after
// reset; popping a never-written frame returns garbage.
module multi_ring_frame_buffer_unit import mrfb_pkg::*; #(
   parameter int RING_COUNT = 32,
   parameter int RING_DEPTH = 8192,
   parameter int GEN_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [LEVEL_W-1:0] csr_write_data,
   mrfb_req_if.sink           req,
   mrfb_rsp_if.source         rsp
);

   localparam int RID_W = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
   localparam int POS_W = $clog2(RING_DEPTH);
   localparam int CNT_W = POS_W + 1;
   localparam int ADR_W = RID_W + POS_W;
   localparam int CAP_W = ((LEVEL_W > CNT_W) ? LEVEL_W : CNT_W) + 1;
   localparam int CMP_W = (GEN_BITS > TAG_W) ? GEN_BITS : TAG_W;

   logic [LEVEL_W-1:0] cap_ff;
   logic [RING_COUNT-1:0] busy_ff, endm_ff;
   logic [GEN_BITS-1:0] gen_ff [RING_COUNT];
   logic [POS_W-1:0] wr_ff [RING_COUNT];
   logic [POS_W-1:0] rd_ff [RING_COUNT];
   logic [CNT_W-1:0] cnt_ff [RING_COUNT];
   logic [63:0] mem [RING_COUNT*RING_DEPTH];
   logic [63:0] mem_q_ff;

   logic busy_stage_ff;
   req_type req_ff;
   logic [RID_W-1:0] ring_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   // effective capacity, saturated to the built depth
   logic [CNT_W:0] cap_eff;
   assign cap_eff = (CAP_W'(cap_ff) > CAP_W'(RING_DEPTH))
                    ? (CNT_W+1)'(RING_DEPTH) : (CNT_W+1)'(cap_ff);

   logic take_ok;
   assign take_ok = !rsp_valid_ff || rsp.ready;
   assign req.ready = !busy_stage_ff && take_ok;
   logic acc;
   assign acc = req.valid && req.ready;

   // wrap the ring index into the pool with a constant table
   logic [RID_W-1:0] rid_in;
   always_comb begin
      rid_in = '0;
      for (int i = 0; i < (1 << RING_W); i++) begin
         if (req.payload.ring_id == RING_W'(i)) rid_in = RID_W'(i % RING_COUNT);
      end
   end

   // lowest free ring
   logic [RID_W-1:0] free_idx;
   always_comb begin
      free_idx = '0;
      for (int i = RING_COUNT-1; i >= 0; i--) begin
         if (!busy_ff[i]) free_idx = RID_W'(i);
      end
   end

   logic [RID_W-1:0] r;
   assign r = ring_ff;
   logic match;
   assign match = (CMP_W'(req_ff.gen_tag) == CMP_W'(gen_ff[r]));

   function automatic logic [POS_W-1:0] nxt(input logic [POS_W-1:0] p,
                                            input logic [CNT_W:0] c);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(p) + 1'b1;
      return (s >= c) ? '0 : s[POS_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (acc && req.payload.cmd == CMD_POP)
         mem_q_ff <= mem[{rid_in, rd_ff[rid_in]}];
      if (busy_stage_ff && req_ff.cmd == CMD_PUSH && match &&
          (CNT_W+1)'(cnt_ff[r]) < cap_eff)
         mem[ADR_W'({r, wr_ff[r]})] <= {req_ff.right_sample, req_ff.left_sample};
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         req_ff  <= req.payload;
         ring_ff <= (req.payload.cmd == CMD_ACQUIRE) ? free_idx : rid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= LEVEL_W'(8192);
         busy_ff <= '0;
         endm_ff <= '0;
         busy_stage_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RING_COUNT; i++) begin
            gen_ff[i] <= '0;
            wr_ff[i]  <= '0;
            rd_ff[i]  <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) cap_ff <= csr_write_data;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         busy_stage_ff <= acc;
         if (busy_stage_ff) begin
            logic [2:0] st;
            logic [GEN_BITS-1:0] g;
            logic [CNT_W-1:0] c;
            logic e;
            logic [63:0] d;
            st = ST_OK;
            g = gen_ff[r];
            c = cnt_ff[r];
            e = endm_ff[r];
            d = '0;
            case (req_ff.cmd)
               CMD_ACQUIRE: begin
                  // a busy chosen ring means none was free
                  if (!busy_ff[r]) begin
                     busy_ff[r] <= 1'b1;
                     wr_ff[r] <= '0;
                     rd_ff[r] <= '0;
                     cnt_ff[r] <= '0;
                     endm_ff[r] <= 1'b0;
                     c = '0;
                     e = 1'b0;
                  end else st = ST_NO_RING;
               end
               CMD_RELEASE: begin
                  g = g + 1'b1;
                  gen_ff[r] <= g;
                  busy_ff[r] <= 1'b0;
               end
               CMD_PUSH: begin
                  if (!match) st = ST_STALE;
                  else if ((CNT_W+1)'(c) >= cap_eff) st = ST_FULL;
                  else begin
                     wr_ff[r] <= nxt(wr_ff[r], cap_eff);
                     c = c + 1'b1;
                     cnt_ff[r] <= c;
                  end
               end
               CMD_POP: begin
                  if (c == '0) st = ST_EMPTY;
                  else begin
                     d = mem_q_ff;
                     rd_ff[r] <= nxt(rd_ff[r], cap_eff);
                     c = c - 1'b1;
                     cnt_ff[r] <= c;
                  end
               end
               CMD_MARK_END: begin
                  if (match) begin
                     endm_ff[r] <= 1'b1;
                     e = 1'b1;
                  end else st = ST_STALE;
               end
               default: ;
            endcase
            rsp_valid_ff <= 1'b1;
            rsp_ff.status <= st;
            if (st == ST_NO_RING) begin
               rsp_ff.ring_out <= '0;
               rsp_ff.gen_out  <= '0;
               rsp_ff.level    <= '0;
               rsp_ff.end_flag <= 1'b0;
            end else begin
               rsp_ff.ring_out <= RING_W'(r);
               rsp_ff.gen_out  <= TAG_W'(g);
               rsp_ff.level    <= LEVEL_W'(c);
               rsp_ff.end_flag <= e;
            end
            rsp_ff.left_out  <= d[31:0];
            rsp_ff.right_out <= d[63:32];
         end
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   a_no_accept_in_stage: assert property (@(posedge clock) disable iff (reset)
      busy_stage_ff |-> !req.ready) else $error("accept during update");
   a_rsp_after_stage: assert property (@(posedge clock) disable iff (reset)
      busy_stage_ff |=> rsp_valid_ff) else $error("response lost");
   a_pop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_OK) |-> (rsp_ff.left_out == '0))
      else $error("data on failed pop");

endmodule
